// ===== hw/rtl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// shared constants, types and helpers of the bilinear pixel sampler
// ----------------------------------------------------------------------------
package bps_pkg;

    // image store geometry and coordinate format
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int FRAC_BITS  = 8;

    // fixed field widths
    localparam int COORD_W  = 18;
    localparam int WCOL_W   = 9;
    localparam int WROW_W   = 9;
    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 3 * CHAN_W;
    localparam int LEVEL_W  = 16;
    localparam int REG_W    = 10;
    localparam int RESET_DIM = 512;

    // derived widths
    localparam int COL_W = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
    localparam int ROW_W = ($clog2(MAX_HEIGHT) < 2) ? 2 : $clog2(MAX_HEIGHT);
    localparam int DIM_W = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
    localparam int CMP_W = COORD_W + FRAC_BITS + DIM_W + REG_W;
    localparam int BANK_AW  = (COL_W - 1) + (ROW_W - 1);
    localparam int NUM_BANKS = 4;
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int PROD_W = WGT_W + CHAN_W;
    localparam int SUM_W  = PROD_W;
    localparam int RND_W  = SUM_W + 8;

    // configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_SEL_BIT = 2;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [PIXEL_W-1:0] t_pixel;

    // effective image size after clamping
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_dims;

    // sample context alongside the memory read
    typedef struct packed {
        logic                 in_range;
        logic                 at_border;
        logic                 ix_odd;
        logic                 iy_odd;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
    } t_s1;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [REG_W-1:0] v, int maxv);
        logic [CMP_W-1:0] vz;
        logic [DIM_W-1:0] res;
        vz = CMP_W'(v);
        if (vz == '0) begin
            res = DIM_W'(1);
        end else if (vz > CMP_W'(maxv)) begin
            res = DIM_W'(maxv);
        end else begin
            res = vz[DIM_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/bps_if.sv =====
// ----------------------------------------------------------------------------
// bps interfaces
// request and result channels of the bilinear pixel sampler
// ----------------------------------------------------------------------------
interface bps_req_if;
    import bps_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;
    logic [WCOL_W-1:0]         write_col;
    logic [WROW_W-1:0]         write_row;
    logic [CHAN_W-1:0]         write_blue;
    logic [CHAN_W-1:0]         write_green;
    logic [CHAN_W-1:0]         write_red;

    modport source (output valid, mode, sample_x, sample_y, write_col, write_row,
                    write_blue, write_green, write_red, input ready);
    modport sink   (input valid, mode, sample_x, sample_y, write_col, write_row,
                    write_blue, write_green, write_red, output ready);
    modport monitor (input valid, ready, mode, sample_x, sample_y, write_col,
                     write_row, write_blue, write_green, write_red);
endinterface

interface bps_res_if;
    import bps_pkg::*;
    logic               valid;
    logic               ready;
    logic               in_range;
    logic [LEVEL_W-1:0] blue_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] red_level;

    modport source  (output valid, in_range, blue_level, green_level, red_level,
                     input ready);
    modport sink    (input valid, in_range, blue_level, green_level, red_level,
                     output ready);
    modport monitor (input valid, ready, in_range, blue_level, green_level, red_level);
endinterface

// ===== hw/rtl/bps_ram.sv =====
// ----------------------------------------------------------------------------
// bps_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bps_ram #(
    parameter int DATA_W = 24,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);
    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== hw/rtl/bps_cfg.sv =====
// ----------------------------------------------------------------------------
// bps_cfg
// apb register file holding the image size
// ----------------------------------------------------------------------------
module bps_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bps_pkg::PADDR_W-1:0] paddr,
    input  logic [bps_pkg::PDATA_W-1:0] pwdata,
    output logic [bps_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output bps_pkg::t_dims              o_dims
);
    import bps_pkg::*;

    logic [REG_W-1:0] r_image_width;
    logic [REG_W-1:0] r_image_height;
    logic             wr_stb;
    t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_stb  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[REG_SEL_BIT]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= REG_W'(RESET_DIM);
            r_image_height <= REG_W'(RESET_DIM);
        end else if (wr_stb) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[REG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[REG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(r_image_height);
        endcase
    end

    // zero acts as one, oversize acts as the store limit
    assign o_dims.width  = clamp_dim(r_image_width, MAX_WIDTH);
    assign o_dims.height = clamp_dim(r_image_height, MAX_HEIGHT);
endmodule

// ===== hw/rtl/bps_fetch.sv =====
// ----------------------------------------------------------------------------
// bps_fetch
// request decode, range check and parity-banked pixel store
// ----------------------------------------------------------------------------
module bps_fetch (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    bps_req_if.sink                i_req,
    input  bps_pkg::t_dims         i_dims,
    input  logic                   i_s2_free,
    output logic                   o_s1_valid,
    output bps_pkg::t_s1           o_s1,
    output bps_pkg::t_pixel        o_bank_data [bps_pkg::NUM_BANKS]
);
    import bps_pkg::*;

    logic                   free1;
    logic                   accept;
    logic                   smp_acc;
    logic [CMP_W-1:0]       xz, yz, bound_x, bound_y;
    logic [CMP_W-1:0]       wcol_z, wrow_z;
    logic                   out_of_range;
    logic [COL_W-1:0]       ix, ix_p1, wcol;
    logic [ROW_W-1:0]       iy, iy_p1, wrow;
    logic                   wr_ok;
    logic [BANK_AW-1:0]     wr_addr;
    logic [BANK_AW-1:0]     rd_addr [NUM_BANKS];
    logic [NUM_BANKS-1:0]   wr_en;
    t_pixel                 wr_data;
    t_s1                    n_s1;
    logic                   r_s1_valid;
    t_s1                    r_s1;

    assign free1       = !r_s1_valid || i_s2_free;
    assign i_req.ready = free1;
    assign accept      = i_req.valid && free1;
    assign smp_acc     = accept && i_req.mode;

    always_comb begin
        xz      = CMP_W'($unsigned(i_req.sample_x));
        yz      = CMP_W'($unsigned(i_req.sample_y));
        bound_x = (CMP_W'(i_dims.width) - CMP_W'(1)) << FRAC_BITS;
        bound_y = (CMP_W'(i_dims.height) - CMP_W'(1)) << FRAC_BITS;
        out_of_range = i_req.sample_x[COORD_W-1] || i_req.sample_y[COORD_W-1] ||
                       (xz > bound_x) || (yz > bound_y);
        ix    = xz[FRAC_BITS +: COL_W];
        iy    = yz[FRAC_BITS +: ROW_W];
        ix_p1 = ix + COL_W'(1);
        iy_p1 = iy + ROW_W'(1);

        n_s1.in_range  = !out_of_range;
        n_s1.at_border = (CMP_W'(ix) + CMP_W'(1) >= CMP_W'(i_dims.width)) ||
                         (CMP_W'(iy) + CMP_W'(1) >= CMP_W'(i_dims.height));
        n_s1.ix_odd    = ix[0];
        n_s1.iy_odd    = iy[0];
        n_s1.fx        = i_req.sample_x[FRAC_BITS-1:0];
        n_s1.fy        = i_req.sample_y[FRAC_BITS-1:0];

        // each parity bank holds exactly one of the four neighbors
        for (int b = 0; b < NUM_BANKS; b++) begin
            logic [COL_W-1:0] cb;
            logic [ROW_W-1:0] rb;
            cb = (ix[0] == b[0]) ? ix : ix_p1;
            rb = (iy[0] == b[1]) ? iy : iy_p1;
            rd_addr[b] = {rb[ROW_W-1:1], cb[COL_W-1:1]};
        end

        // writes beyond the store are dropped
        wcol_z  = CMP_W'(i_req.write_col);
        wrow_z  = CMP_W'(i_req.write_row);
        wr_ok   = (wcol_z < CMP_W'(MAX_WIDTH)) && (wrow_z < CMP_W'(MAX_HEIGHT));
        wcol    = wcol_z[COL_W-1:0];
        wrow    = wrow_z[ROW_W-1:0];
        wr_addr = {wrow[ROW_W-1:1], wcol[COL_W-1:1]};
        wr_data = {i_req.write_red, i_req.write_green, i_req.write_blue};
        for (int b = 0; b < NUM_BANKS; b++) begin
            wr_en[b] = accept && !i_req.mode && wr_ok &&
                       (wrow[0] == b[1]) && (wcol[0] == b[0]);
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        bps_ram #(
            .DATA_W (PIXEL_W),
            .ADDR_W (BANK_AW)
        ) u_bank (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en[g]),
            .i_wr_addr (wr_addr),
            .i_wr_data (wr_data),
            .i_rd_en   (smp_acc),
            .i_rd_addr (rd_addr[g]),
            .o_rd_data (o_bank_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (free1) begin
            r_s1_valid <= smp_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
endmodule

// ===== hw/rtl/bps_blend.sv =====
// ----------------------------------------------------------------------------
// bps_blend
// neighbor routing, weights, products and rounded sum per channel
// ----------------------------------------------------------------------------
module bps_blend (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s1_valid,
    input  bps_pkg::t_s1           i_s1,
    input  bps_pkg::t_pixel        i_bank_data [bps_pkg::NUM_BANKS],
    output logic                   o_s2_free,
    bps_res_if.source              o_res
);
    import bps_pkg::*;

    localparam logic [FRAC_BITS:0] ONE   = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [RND_W-1:0]   HALF  = RND_W'(1) << (2 * FRAC_BITS - 1);

    typedef struct packed {
        logic                                 in_range;
        logic [NUM_BANKS-1:0][WGT_W-1:0]      weight;
        logic [NUM_BANKS-1:0][PIXEL_W-1:0]    pix;
    } t_s2;

    typedef struct packed {
        logic                                  in_range;
        logic [2:0][NUM_BANKS-1:0][PROD_W-1:0] prod;
    } t_s3;

    logic                  r_v2, r_v3, r_v4;
    t_s2                   r_s2, n_s2;
    t_s3                   r_s3, n_s3;
    logic                  r_in_range;
    logic [2:0][LEVEL_W-1:0] r_level, n_level;
    logic                  free2, free3, free4;
    logic [FRAC_BITS:0]    fxc, fyc;
    logic [1:0]            b00, b01, b10, b11;

    assign free4     = !r_v4 || o_res.ready;
    assign free3     = !r_v3 || free4;
    assign free2     = !r_v2 || free3;
    assign o_s2_free = free2;

    // stage 2: route banks to neighbors and form the weights
    always_comb begin
        fxc = ONE - (FRAC_BITS+1)'(i_s1.fx);
        fyc = ONE - (FRAC_BITS+1)'(i_s1.fy);
        b00 = {i_s1.iy_odd, i_s1.ix_odd};
        b01 = {i_s1.iy_odd, !i_s1.ix_odd};
        b10 = {!i_s1.iy_odd, i_s1.ix_odd};
        b11 = {!i_s1.iy_odd, !i_s1.ix_odd};
        n_s2.in_range = i_s1.in_range;
        n_s2.pix[0] = i_s1.in_range ? i_bank_data[b00] : '0;
        n_s2.pix[1] = (i_s1.in_range && !i_s1.at_border) ? i_bank_data[b01] : '0;
        n_s2.pix[2] = (i_s1.in_range && !i_s1.at_border) ? i_bank_data[b10] : '0;
        n_s2.pix[3] = (i_s1.in_range && !i_s1.at_border) ? i_bank_data[b11] : '0;
        priority if (!i_s1.in_range) begin
            n_s2.weight = '0;
        end else if (i_s1.at_border) begin
            // full weight on the top-left pixel
            n_s2.weight    = '0;
            n_s2.weight[0] = WGT_W'(1) << (2 * FRAC_BITS);
        end else begin
            n_s2.weight[0] = WGT_W'(fxc) * WGT_W'(fyc);
            n_s2.weight[1] = WGT_W'(i_s1.fx) * WGT_W'(fyc);
            n_s2.weight[2] = WGT_W'(fxc) * WGT_W'(i_s1.fy);
            n_s2.weight[3] = WGT_W'(i_s1.fx) * WGT_W'(i_s1.fy);
        end
    end

    // stage 3: one product per neighbor and channel
    always_comb begin
        n_s3.in_range = r_s2.in_range;
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < NUM_BANKS; k++) begin
                n_s3.prod[c][k] = PROD_W'(r_s2.weight[k]) *
                                  PROD_W'(r_s2.pix[k][CHAN_W*c +: CHAN_W]);
            end
        end
    end

    // stage 4: sum and round half up into 8.8
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [SUM_W-1:0] sum;
            logic [RND_W-1:0] rnd;
            sum = r_s3.prod[c][0] + r_s3.prod[c][1] + r_s3.prod[c][2] + r_s3.prod[c][3];
            rnd = {sum, 8'b0} + HALF;
            n_level[c] = rnd[2 * FRAC_BITS +: LEVEL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (free2) begin
                r_v2 <= i_s1_valid;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
            if (free4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free2 && i_s1_valid) begin
            r_s2 <= n_s2;
        end
        if (free3 && r_v2) begin
            r_s3 <= n_s3;
        end
        if (free4 && r_v3) begin
            r_level    <= n_level;
            r_in_range <= r_s3.in_range;
        end
    end

    assign o_res.valid       = r_v4;
    assign o_res.in_range    = r_in_range;
    assign o_res.blue_level  = r_level[0];
    assign o_res.green_level = r_level[1];
    assign o_res.red_level   = r_level[2];
endmodule

// ===== hw/rtl/bilinear_pixel_sampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_pixel_sampler
// rgb pixel store with a streaming bilinear sampler
// ----------------------------------------------------------------------------
//
//  channel   role    handshake      request / result
//  i_req     sink    valid/ready    pixel write (mode 0) or sample (mode 1)
//  o_res     source  valid/ready    one result per sample, none per write
//  apb       slave   psel/penable   image_width at 0x0, image_height at 0x4
//
//  one request per cycle unless o_res back-pressure holds i_req.ready low
//  memory read, weights, products and rounded sum each take one stage
//  the store is four parity banks, so all four neighbors come from one read
//  a stalled result holds the pipeline stage by stage; bubbles still drain
//  synchronous active-low reset clears pipeline valids and the size registers
//  pixel store is not cleared: only written pixels may be sampled
//
module bilinear_pixel_sampler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bps_req_if.sink                     i_req,
    bps_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bps_pkg::PADDR_W-1:0] paddr,
    input  logic [bps_pkg::PDATA_W-1:0] pwdata,
    output logic [bps_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import bps_pkg::*;

    t_dims  dims;
    logic   s1_valid;
    t_s1    s1;
    logic   s2_free;
    t_pixel bank_data [NUM_BANKS];

    // image size registers, clamped to the store limits
    bps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dims  (dims)
    );

    // writes go straight into a bank, samples issue four parallel reads
    bps_fetch u_fetch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_dims      (dims),
        .i_s2_free   (s2_free),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1),
        .o_bank_data (bank_data)
    );

    // weighting and rounding pipeline, ends in the result register
    bps_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_bank_data (bank_data),
        .o_s2_free   (s2_free),
        .o_res       (o_res)
    );
endmodule

// ===== hw/rtl/bps_checker.sv =====
// ----------------------------------------------------------------------------
// bps_checker
// port-level checks of the bilinear pixel sampler, bound to the top level
// ----------------------------------------------------------------------------
module bps_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  logic                        i_res_in_range,
    input  logic [bps_pkg::LEVEL_W-1:0] i_blue_level,
    input  logic [bps_pkg::LEVEL_W-1:0] i_green_level,
    input  logic [bps_pkg::LEVEL_W-1:0] i_red_level,
    input  logic                        psel,
    input  logic                        pready
);
    import bps_pkg::*;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(16'hFF00);

    // a stalled result keeps its value
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_in_range) &&
        $stable(i_blue_level) && $stable(i_green_level) &&
        $stable(i_red_level))
        else $error("result changed while stalled");

    // out-of-range samples carry zero levels
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_in_range |->
        i_blue_level == '0 && i_green_level == '0 && i_red_level == '0)
        else $error("out-of-range result with nonzero level");

    // blended levels never exceed 255.0 in 8.8
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_blue_level <= LEVEL_MAX &&
        i_green_level <= LEVEL_MAX && i_red_level <= LEVEL_MAX)
        else $error("level above full scale");

    // register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("apb pready low");

    // no result is offered on the cycle after a reset edge
    a_rdy_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");
endmodule

bind bilinear_pixel_sampler bps_checker u_bps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_in_range (o_res.in_range),
    .i_blue_level   (o_res.blue_level),
    .i_green_level  (o_res.green_level),
    .i_red_level    (o_res.red_level),
    .psel           (psel),
    .pready         (pready)
);

// ===== tb/tb_bilinear_pixel_sampler.sv =====
// ----------------------------------------------------------------------------
// tb_bilinear_pixel_sampler
// self-checking bench for the bilinear rgb pixel sampler
//
// pixel writes and fractional samples stream into the request channel while
// both sides idle and stall at random. a scoreboard mirrors the pixel store
// and the image size registers, predicts each sample result and checks every
// result field in order. the run walks through several image sizes, the
// smallest, the largest, a zero and an oversized register value among them.
// every sample only touches pixels that were written before it.
// ----------------------------------------------------------------------------
module tb_bilinear_pixel_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    // request kinds on the mode bit
    typedef enum bit {
        MODE_WRITE  = 1'b0,
        MODE_SAMPLE = 1'b1
    } t_op_mode;

    typedef struct {
        t_op_mode                  mode;
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic [WCOL_W-1:0]         write_col;
        logic [WROW_W-1:0]         write_row;
        logic [CHAN_W-1:0]         write_blue;
        logic [CHAN_W-1:0]         write_green;
        logic [CHAN_W-1:0]         write_red;
    } t_pixel_req;

    typedef struct {
        logic               in_range;
        logic [LEVEL_W-1:0] blue_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] red_level;
    } t_level_res;

    // ------------------------------------------------------------------------
    // scoreboard: mirrored pixel store, size registers, expected levels
    // ------------------------------------------------------------------------
    class blend_scoreboard;
        logic [PIXEL_W-1:0] pixel_mem [int];
        int unsigned        width_reg;
        int unsigned        height_reg;
        t_level_res         pending_levels [$];
        int unsigned        errors;

        function new();
            width_reg  = RESET_DIM;
            height_reg = RESET_DIM;
            errors     = 0;
        endfunction

        // zero acts as one, oversized values saturate at the store size
        static function int unsigned fit_dim(int unsigned v, int unsigned limit);
            if (v == 0) begin
                return 1;
            end
            return (v > limit) ? limit : v;
        endfunction

        function int unsigned eff_width();
            return fit_dim(width_reg, MAX_WIDTH);
        endfunction

        function int unsigned eff_height();
            return fit_dim(height_reg, MAX_HEIGHT);
        endfunction

        function void note_config(t_reg_idx idx, logic [PDATA_W-1:0] data);
            if (idx == REG_IMAGE_WIDTH) begin
                width_reg = data[REG_W-1:0];
            end else begin
                height_reg = data[REG_W-1:0];
            end
        endfunction

        function logic [PIXEL_W-1:0] read_pixel(int unsigned col, int unsigned row);
            int addr;
            addr = row * MAX_WIDTH + col;
            if (pixel_mem.exists(addr)) begin
                return pixel_mem[addr];
            end
            return '0;
        endfunction

        function t_level_res blend(longint x, longint y);
            t_level_res         res;
            int unsigned        w, h, ix, iy, fx, fy, unit;
            logic [PIXEL_W-1:0] px [4];
            longint unsigned    wt [4];
            longint unsigned    acc, rounded;
            logic [LEVEL_W-1:0] lv [3];
            w    = eff_width();
            h    = eff_height();
            unit = 1 << FRAC_BITS;
            res.in_range    = 1'b0;
            res.blue_level  = '0;
            res.green_level = '0;
            res.red_level   = '0;
            if (x < 0 || y < 0 || x > (longint'(w - 1) << FRAC_BITS) ||
                y > (longint'(h - 1) << FRAC_BITS)) begin
                return res;
            end
            ix = int'(x >> FRAC_BITS);
            iy = int'(y >> FRAC_BITS);
            fx = int'(x) & (unit - 1);
            fy = int'(y) & (unit - 1);
            res.in_range = 1'b1;
            px[0] = read_pixel(ix, iy);
            // lower-right neighbor off the image: plain top-left pixel
            if (ix + 1 >= w || iy + 1 >= h) begin
                res.blue_level  = {px[0][7:0], 8'h00};
                res.green_level = {px[0][15:8], 8'h00};
                res.red_level   = {px[0][23:16], 8'h00};
                return res;
            end
            px[1] = read_pixel(ix + 1, iy);
            px[2] = read_pixel(ix, iy + 1);
            px[3] = read_pixel(ix + 1, iy + 1);
            wt[0] = (unit - fx) * (unit - fy);
            wt[1] = fx * (unit - fy);
            wt[2] = (unit - fx) * fy;
            wt[3] = fx * fy;
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) begin
                    acc += wt[k] * px[k][8*c +: 8];
                end
                rounded = ((acc << 8) + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
                lv[c] = rounded[LEVEL_W-1:0];
            end
            res.blue_level  = lv[0];
            res.green_level = lv[1];
            res.red_level   = lv[2];
            return res;
        endfunction

        function void note_request(t_pixel_req r);
            if (r.mode == MODE_WRITE) begin
                pixel_mem[int'(r.write_row) * MAX_WIDTH + int'(r.write_col)] =
                    {r.write_red, r.write_green, r.write_blue};
            end else begin
                pending_levels.insert(pending_levels.size(),
                                      blend(r.sample_x, r.sample_y));
            end
        endfunction

        function void check_result(t_level_res got);
            t_level_res exp;
            if (pending_levels.size() == 0) begin
                $error("result with no sample outstanding");
                errors++;
                return;
            end
            exp = pending_levels.pop_front();
            if (got.in_range !== exp.in_range) begin
                $error("in_range: expected %0d, got %0d", exp.in_range, got.in_range);
                errors++;
            end
            if (got.blue_level !== exp.blue_level) begin
                $error("blue_level: expected %0h, got %0h", exp.blue_level, got.blue_level);
                errors++;
            end
            if (got.green_level !== exp.green_level) begin
                $error("green_level: expected %0h, got %0h", exp.green_level,
                       got.green_level);
                errors++;
            end
            if (got.red_level !== exp.red_level) begin
                $error("red_level: expected %0h, got %0h", exp.red_level, got.red_level);
                errors++;
            end
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction

        function void flag_leftovers();
            if (pending_levels.size() != 0) begin
                $error("%0d sample results never arrived", pending_levels.size());
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block itself
    // ------------------------------------------------------------------------
    localparam int RANDOM_PER_PHASE = 30;
    localparam int SETTLE_CYCLES    = 8;    // pipeline is 4 deep, writes give no result
    localparam int DRAIN_LIMIT      = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bps_req_if req_if ();
    bps_res_if res_if ();

    blend_scoreboard sb = new();

    // pixels the stimulus has already written, so samples never read garbage
    bit  stim_written [int];
    // sender gaps on or off for the current phase
    bit  gaps_on;

    bilinear_pixel_sampler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // hard stop in case the block hangs
    initial begin
        #40_000_000;
        $display("bilinear_pixel_sampler verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // monitor: every handshake is seen at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel_req r;
        t_level_res got;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.in_range    = res_if.in_range;
                got.blue_level  = res_if.blue_level;
                got.green_level = res_if.green_level;
                got.red_level   = res_if.red_level;
                sb.check_result(got);
            end
            if (req_if.valid && req_if.ready) begin
                r.mode        = t_op_mode'(req_if.mode);
                r.sample_x    = req_if.sample_x;
                r.sample_y    = req_if.sample_y;
                r.write_col   = req_if.write_col;
                r.write_row   = req_if.write_row;
                r.write_blue  = req_if.write_blue;
                r.write_green = req_if.write_green;
                r.write_red   = req_if.write_red;
                sb.note_request(r);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side back-pressure: short stalls, rare long ones, open stretches
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        int open;
        res_if.ready = 1'b1;
        @(posedge i_rst_n);
        forever begin
            case ($urandom_range(0, 19)) inside
                [0:13]:  stall = $urandom_range(1, 2);
                [14:18]: stall = $urandom_range(3, 8);
                default: stall = $urandom_range(15, 40);
            endcase
            open = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                              : $urandom_range(1, 6);
            @(negedge i_clk);
            res_if.ready = 1'b0;
            repeat (stall - 1) @(negedge i_clk);
            @(negedge i_clk);
            res_if.ready = 1'b1;
            repeat (open - 1) @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------------

    // idle cycles before the next request: mostly none, now and then long
    function automatic int idle_len();
        if (!gaps_on) begin
            return 0;
        end
        case ($urandom_range(0, 99)) inside
            [0:54]:  return 0;
            [55:84]: return $urandom_range(1, 3);
            [85:96]: return $urandom_range(4, 12);
            default: return $urandom_range(20, 60);
        endcase
    endfunction

    // valid stays high across back-to-back requests, changed at falling edges
    task automatic push_request(input t_pixel_req r);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.mode        = r.mode;
        req_if.sample_x    = r.sample_x;
        req_if.sample_y    = r.sample_y;
        req_if.write_col   = r.write_col;
        req_if.write_row   = r.write_row;
        req_if.write_blue  = r.write_blue;
        req_if.write_green = r.write_green;
        req_if.write_red   = r.write_red;
        req_if.valid       = 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic release_requests();
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    // pixel write; the coordinate fields are don't-care and get noise
    task automatic send_write(input int col, input int row,
                              input logic [7:0] blue, input logic [7:0] green,
                              input logic [7:0] red);
        t_pixel_req r;
        r.mode        = MODE_WRITE;
        r.sample_x    = COORD_W'($urandom);
        r.sample_y    = COORD_W'($urandom);
        r.write_col   = WCOL_W'(col);
        r.write_row   = WROW_W'(row);
        r.write_blue  = blue;
        r.write_green = green;
        r.write_red   = red;
        stim_written[row * MAX_WIDTH + col] = 1'b1;
        push_request(r);
    endtask

    // sample request, preceded by writes of any neighbor not yet stored
    task automatic send_sample(input int x, input int y);
        t_pixel_req r;
        int         w, h, ix, iy;
        w = sb.eff_width();
        h = sb.eff_height();
        if (x >= 0 && y >= 0 && x <= ((w - 1) << FRAC_BITS) &&
            y <= ((h - 1) << FRAC_BITS)) begin
            ix = x >>> FRAC_BITS;
            iy = y >>> FRAC_BITS;
            for (int dy = 0; dy < 2; dy++) begin
                for (int dx = 0; dx < 2; dx++) begin
                    if (ix + dx < MAX_WIDTH && iy + dy < MAX_HEIGHT &&
                        !stim_written.exists((iy + dy) * MAX_WIDTH + ix + dx)) begin
                        send_write(ix + dx, iy + dy, 8'($urandom), 8'($urandom),
                                   8'($urandom));
                    end
                end
            end
        end
        r.mode        = MODE_SAMPLE;
        r.sample_x    = COORD_W'(x);
        r.sample_y    = COORD_W'(y);
        r.write_col   = WCOL_W'($urandom);
        r.write_row   = WROW_W'($urandom);
        r.write_blue  = 8'($urandom);
        r.write_green = 8'($urandom);
        r.write_red   = 8'($urandom);
        push_request(r);
    endtask

    // ------------------------------------------------------------------------
    // configuration port: setup then access, upper data bits are noise
    // ------------------------------------------------------------------------
    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        logic [PDATA_W-1:0] data;
        data = $urandom;
        data[REG_W-1:0] = value[REG_W-1:0];
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(idx) << REG_SEL_BIT;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.note_config(idx, data);
    endtask

    // let every sample come back, then give trailing writes time to land
    task automatic wait_idle();
        release_requests();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // random traffic within the current image size
    // ------------------------------------------------------------------------
    task automatic run_random(input int count, input bit hold_off);
        int w, h, xmax, ymax, x, y;
        w    = sb.eff_width();
        h    = sb.eff_height();
        xmax = (w - 1) << FRAC_BITS;
        ymax = (h - 1) << FRAC_BITS;
        for (int i = 0; i < count; i++) begin
            // sender holds off until the pipeline has fully drained
            if (hold_off && i == count / 2) begin
                release_requests();
                while (sb.pending() != 0) @(posedge i_clk);
            end
            case ($urandom_range(0, 99)) inside
                [0:54]: begin
                    // interior blend
                    send_sample($urandom_range(0, xmax), $urandom_range(0, ymax));
                end
                [55:66]: begin
                    // last column or last row: no lower-right neighbor
                    if ($urandom_range(0, 1)) begin
                        send_sample(xmax, $urandom_range(0, ymax));
                    end else begin
                        send_sample($urandom_range(0, xmax), ymax);
                    end
                end
                [67:76]: begin
                    // just past an image border
                    case ($urandom_range(0, 3))
                        0:       x = -$urandom_range(1, 300);
                        1:       x = xmax + $urandom_range(1, 300);
                        default: x = $urandom_range(0, xmax);
                    endcase
                    y = (x >= 0 && x <= xmax) ?
                        (($urandom_range(0, 1)) ? -$urandom_range(1, 300)
                                                : ymax + $urandom_range(1, 300))
                        : $urandom_range(0, ymax);
                    send_sample(x, y);
                end
                [77:86]: begin
                    // full coordinate range, mostly out of range
                    x = $signed(COORD_W'($urandom));
                    y = $signed(COORD_W'($urandom));
                    send_sample(x, y);
                end
                [87:93]: begin
                    send_write($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                               8'($urandom), 8'($urandom), 8'($urandom));
                end
                default: begin
                    // anywhere in the store, also outside the configured image
                    send_write($urandom_range(0, MAX_WIDTH - 1),
                               $urandom_range(0, MAX_HEIGHT - 1),
                               8'($urandom), 8'($urandom), 8'($urandom));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        // register values per phase: smallest, zero, oversized, one-sided sizes
        int unsigned phase_w [] = '{1, 2, 0, 1023, 7, 512, 513, 16, 3};
        int unsigned phase_h [] = '{1, 3, 0, 1023, 512, 5, 2, 16, 1};
        int          dir_x   [] = '{0, 128, 255, 1, 511 << 8, (510 << 8) + 255,
                                    (510 << 8) + 192, -1, 0, (511 << 8) + 1, 0,
                                    131071, -131072};
        int          dir_y   [] = '{0, 128, 1, 255, 511 << 8, 511 << 8,
                                    (510 << 8) + 64, 0, -1, 0, (511 << 8) + 1,
                                    131071, -131072};
        int          waited;

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_if.valid       = 1'b0;
        req_if.mode        = MODE_WRITE;
        req_if.sample_x    = '0;
        req_if.sample_y    = '0;
        req_if.write_col   = '0;
        req_if.write_row   = '0;
        req_if.write_blue  = '0;
        req_if.write_green = '0;
        req_if.write_red   = '0;
        gaps_on            = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: corner pixels with extreme and alternating channel bytes,
        // run at the reset size of 512 x 512
        send_write(0, 0, 8'h00, 8'hFF, 8'hAA);
        send_write(1, 0, 8'hFF, 8'h00, 8'h55);
        send_write(0, 1, 8'h55, 8'hAA, 8'hFF);
        send_write(1, 1, 8'hAA, 8'h55, 8'h00);
        send_write(511, 511, 8'hFF, 8'hFF, 8'hFF);
        send_write(510, 511, 8'h00, 8'h00, 8'h00);
        send_write(511, 510, 8'h80, 8'h7F, 8'h01);
        send_write(510, 510, 8'h01, 8'hFE, 8'h80);
        // exact hit, half way, lopsided weights, bottom-right corner edge,
        // last-row edge, interior blend, negative and past-the-end axes,
        // and the coordinate field extremes
        foreach (dir_x[k]) begin
            send_sample(dir_x[k], dir_y[k]);
        end

        run_random(RANDOM_PER_PHASE, 1'b1);

        foreach (phase_w[p]) begin
            wait_idle();
            write_reg(REG_IMAGE_WIDTH, phase_w[p]);
            write_reg(REG_IMAGE_HEIGHT, phase_h[p]);
            // every third phase runs the sender flat out
            gaps_on = (p % 3 != 1);
            run_random(RANDOM_PER_PHASE, p == 4);
        end

        // drain, bounded, then settle
        release_requests();
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();

        if (sb.errors == 0) begin
            $display("bilinear_pixel_sampler verification clean");
        end else begin
            $display("bilinear_pixel_sampler verification failed");
        end
        $finish;
    end

endmodule
